FILE: rtl/fixed_chunk_free_list_allocator_defines.svh
// Assertion macros shared by the free-list allocator RTL.
// Included by the controller and datapath modules; no other dependencies.
`ifndef FIXED_CHUNK_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FIXED_CHUNK_FREE_LIST_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check that is disabled while reset is asserted.
`define FCFL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Clocked check that is also evaluated during reset.
`define FCFL_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define FCFL_ASSERT(lbl, prop, msg)
`define FCFL_ASSERT_RST(lbl, prop, msg)
`endif

`endif

FILE: rtl/fcfl_pkg.sv
// Package for the fixed-chunk free-list allocator: sizes, codes and shared types.
// Used by fcfl_ctrl, fcfl_dp and the top level; depends on nothing else.
`default_nettype none

package fcfl_pkg;

    // Pool geometry.
    localparam int CHUNKS_PER_BLOCK = 64;
    localparam int MAX_BLOCKS       = 8;
    localparam int INDEX_SPACE      = 512;

    // Field widths of the transactions.
    localparam int OPC_W   = 2;
    localparam int IDX_W   = 9;
    localparam int STS_W   = 2;
    localparam int FC_W    = 10;
    localparam int BLKO_W  = 4;
    localparam int CNT_W   = 32;

    // Internal widths.
    localparam int ADDR_W  = $clog2(INDEX_SPACE);
    localparam int LIM_W   = $clog2(INDEX_SPACE + 1);
    localparam int BLK_W   = $clog2(MAX_BLOCKS + 1);
    localparam int LINK_W  = ADDR_W + 1;
    localparam logic [FC_W-1:0] CNT_MAX = {FC_W{1'b1}};

    // Packed stream widths, rounded up to whole bytes.
    localparam int IN_DATA_W  = ((IDX_W + 7) / 8) * 8;
    localparam int OUT_BITS   = IDX_W + STS_W + FC_W + BLKO_W + CNT_W + CNT_W + FC_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [OPC_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_CLEANUP = 2'd2,
        OP_NOP     = 2'd3
    } t_opcode;

    typedef enum logic [STS_W-1:0] {
        ST_OK           = 2'd0,
        ST_NO_SPACE     = 2'd1,
        ST_OUT_OF_RANGE = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_POP  = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;      // input transaction accepted this cycle
        logic pop_done;  // link read data is valid, finish the pop
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pop_needed;  // offered item is an allocate served from the list
    } t_dp_status;

    // Number of chunks covered by the given count of taken blocks.
    function automatic logic [LIM_W-1:0] taken_limit(input logic [BLK_W-1:0] blocks);
        logic [31:0] n;
        n = 32'(blocks) * 32'(CHUNKS_PER_BLOCK);
        if (n > 32'(INDEX_SPACE)) begin
            return LIM_W'(INDEX_SPACE);
        end
        return LIM_W'(n);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/fcfl_dp.sv
// Datapath of the allocator: pool state, link memory and result register.
// Depends on fcfl_pkg and the assertion macros in the defines header.
`default_nettype none

`include "fixed_chunk_free_list_allocator_defines.svh"

module fcfl_dp (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire fcfl_pkg::t_dp_cmd        i_cmd,
    output fcfl_pkg::t_dp_status          o_status,
    input  wire [fcfl_pkg::OPC_W-1:0]     i_opcode,
    input  wire [fcfl_pkg::IDX_W-1:0]     i_chunk_index,
    output logic [fcfl_pkg::OUT_DATA_W-1:0] o_result
);
    import fcfl_pkg::*;

    // Pool state.
    logic [ADDR_W-1:0] r_head,     n_head;
    logic              r_nonempty, n_nonempty;
    logic [LIM_W-1:0]  r_fresh,    n_fresh;
    logic [BLK_W-1:0]  r_blocks,   n_blocks;
    logic [FC_W-1:0]   r_fc,       n_fc;
    logic [CNT_W-1:0]  r_alloc,    n_alloc;
    logic [CNT_W-1:0]  r_free,     n_free;

    // Link memory: tail flag above the next index.
    logic [LINK_W-1:0] r_mem [INDEX_SPACE];
    logic [LINK_W-1:0] r_rd;

    // Result register.
    logic [IDX_W-1:0]  r_o_granted;
    t_status           r_o_status;
    logic [FC_W-1:0]   r_o_fc;
    logic [BLKO_W-1:0] r_o_blocks;
    logic [CNT_W-1:0]  r_o_alloc;
    logic [CNT_W-1:0]  r_o_free;
    logic [FC_W-1:0]   r_o_live;

    t_opcode           opcode;
    logic [LIM_W-1:0]  limit;
    logic [LIM_W-1:0]  limit_nx;
    logic [FC_W:0]     fc_sum;
    logic [FC_W-1:0]   fc_grown;
    logic              oob;
    logic              mem_we;
    logic              mem_re;
    logic              load_out;
    logic [IDX_W-1:0]  granted;
    t_status           status;
    logic [FC_W-1:0]   live;

    assign opcode   = t_opcode'(i_opcode);
    assign limit    = taken_limit(r_blocks);
    assign limit_nx = taken_limit(BLK_W'(r_blocks + 1'b1));
    assign oob      = LIM_W'(i_chunk_index) >= limit;

    assign o_status.pop_needed = (opcode == OP_ALLOC) && r_nonempty;

    assign mem_we   = i_cmd.exec && (opcode == OP_FREE) && !oob;
    assign mem_re   = i_cmd.exec && o_status.pop_needed;
    assign load_out = (i_cmd.exec && !o_status.pop_needed) || i_cmd.pop_done;

    // Free count after a new block joins the pool, saturated.
    always_comb begin
        fc_sum = {1'b0, r_fc} + (FC_W+1)'(limit_nx - limit);
        if (fc_sum > (FC_W+1)'(CNT_MAX)) begin
            fc_grown = CNT_MAX;
        end else begin
            fc_grown = fc_sum[FC_W-1:0];
        end
    end

    // Next pool state and result fields.
    always_comb begin
        n_head     = r_head;
        n_nonempty = r_nonempty;
        n_fresh    = r_fresh;
        n_blocks   = r_blocks;
        n_fc       = r_fc;
        n_alloc    = r_alloc;
        n_free     = r_free;
        granted    = '0;
        status     = ST_OK;
        live       = '0;
        if (i_cmd.pop_done) begin
            granted    = r_head;
            n_head     = r_rd[ADDR_W-1:0];
            n_nonempty = !r_rd[LINK_W-1];
            if (r_fc != '0) begin
                n_fc = r_fc - 1'b1;
            end
            n_alloc = r_alloc + 1'b1;
        end else if (i_cmd.exec) begin
            case (opcode)
                OP_ALLOC: begin
                    if (!r_nonempty) begin
                        if (r_fresh < limit) begin
                            granted = IDX_W'(r_fresh);
                            n_fresh = r_fresh + 1'b1;
                            if (r_fc != '0) begin
                                n_fc = r_fc - 1'b1;
                            end
                            n_alloc = r_alloc + 1'b1;
                        end else if ((r_blocks < BLK_W'(MAX_BLOCKS)) &&
                                     (limit != LIM_W'(INDEX_SPACE))) begin
                            n_blocks = r_blocks + 1'b1;
                            granted  = IDX_W'(limit);
                            n_fresh  = limit + 1'b1;
                            if (fc_grown != '0) begin
                                n_fc = fc_grown - 1'b1;
                            end else begin
                                n_fc = fc_grown;
                            end
                            n_alloc = r_alloc + 1'b1;
                        end else begin
                            status = ST_NO_SPACE;
                        end
                    end
                end
                OP_FREE: begin
                    if (oob) begin
                        status = ST_OUT_OF_RANGE;
                    end else begin
                        n_head     = ADDR_W'(i_chunk_index);
                        n_nonempty = 1'b1;
                        if (r_fc != CNT_MAX) begin
                            n_fc = r_fc + 1'b1;
                        end
                        n_free = r_free + 1'b1;
                    end
                end
                OP_CLEANUP: begin
                    if (FC_W'(limit) > r_fc) begin
                        live = FC_W'(limit) - r_fc;
                    end
                    n_nonempty = 1'b0;
                    n_head     = '0;
                    n_fresh    = '0;
                    n_fc       = FC_W'(limit);
                end
                default: begin
                end
            endcase
        end
    end

    // Pool state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_nonempty <= 1'b0;
            r_fresh    <= '0;
            r_blocks   <= '0;
            r_fc       <= '0;
            r_alloc    <= '0;
            r_free     <= '0;
        end else begin
            r_head     <= n_head;
            r_nonempty <= n_nonempty;
            r_fresh    <= n_fresh;
            r_blocks   <= n_blocks;
            r_fc       <= n_fc;
            r_alloc    <= n_alloc;
            r_free     <= n_free;
        end
    end

    // Link memory: a push writes the old head, a pop reads at the head.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[ADDR_W'(i_chunk_index)] <= {!r_nonempty, r_head};
        end
        if (mem_re) begin
            r_rd <= r_mem[r_head];
        end
    end

    // Result register, loaded whenever a transaction completes.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_granted <= granted;
            r_o_status  <= status;
            r_o_fc      <= n_fc;
            r_o_blocks  <= BLKO_W'(n_blocks);
            r_o_alloc   <= n_alloc;
            r_o_free    <= n_free;
            r_o_live    <= live;
        end
    end

    assign o_result = OUT_DATA_W'({r_o_live, r_o_free, r_o_alloc, r_o_blocks,
                                   r_o_fc, r_o_status, r_o_granted});

    // A pop only finishes while the list still holds the entry being taken.
    `FCFL_ASSERT(a_pop_from_list, i_cmd.pop_done |-> r_nonempty, "pop finished on empty list")
    // An accepted in-range free always leaves the list non-empty.
    `FCFL_ASSERT(a_free_fills_list, mem_we |=> r_nonempty, "free did not fill the list")

endmodule

`default_nettype wire

FILE: rtl/fcfl_ctrl.sv
// Controller of the allocator: sequences pops and owns the output handshake.
// Depends on fcfl_pkg and the assertion macros in the defines header.
`default_nettype none

`include "fixed_chunk_free_list_allocator_defines.svh"

module fcfl_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    input  wire fcfl_pkg::t_dp_status i_status,
    output fcfl_pkg::t_dp_cmd     o_cmd
);
    import fcfl_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_fire;
    logic   load_out;

    // State and output-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state         = r_state;
        o_in_ready      = 1'b0;
        o_cmd.exec      = 1'b0;
        o_cmd.pop_done  = 1'b0;
        in_fire         = 1'b0;
        load_out        = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = !r_out_valid || i_out_ready;
                in_fire    = i_in_valid && o_in_ready;
                o_cmd.exec = in_fire;
                if (in_fire) begin
                    if (i_status.pop_needed) begin
                        n_state = S_POP;
                    end else begin
                        load_out = 1'b1;
                    end
                end
            end
            S_POP: begin
                o_cmd.pop_done = 1'b1;
                load_out       = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // The result register is always free while a pop is in flight.
    `FCFL_ASSERT(a_pop_out_free, (r_state == S_POP) |-> !r_out_valid, "pop with result pending")
    // An allocate served from the list always goes through the pop state.
    `FCFL_ASSERT(a_pop_entered, (in_fire && i_status.pop_needed) |=> (r_state == S_POP), "pop skipped")
    // Reset leaves the controller idle with no result offered.
    `FCFL_ASSERT_RST(a_reset_idle, !i_rst_n |=> ((r_state == S_IDLE) && !r_out_valid), "bad reset")

endmodule

`default_nettype wire

FILE: rtl/fixed_chunk_free_list_allocator.sv
// Top level of the fixed-chunk free-list allocator.
// Instantiates fcfl_ctrl and fcfl_dp; depends on fcfl_pkg.
//
//   Channel   Direction  Payload
//   s_axis    in         tuser: opcode; tdata: chunk_index
//   m_axis    out        tdata: granted_index .. live_discarded (one per transaction)
//
// Allocate from the free list passes through the pop state: the link memory
// read is registered before the next head is known. Other operations finish
// from the idle state. Reset is synchronous and active low; no clearing pass
// is needed. A new transaction is taken while the result is being drained, so
// a stalled m_axis holds the block only once its result register is full.
`default_nettype none

module fixed_chunk_free_list_allocator (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // [8:0] chunk_index, rest zero
    input  wire [fcfl_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] opcode
    input  wire [fcfl_pkg::OPC_W-1:0]         s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // [8:0] granted_index, [10:9] status, [20:11] free_chunks,
    // [24:21] blocks_taken, [56:25] alloc_total, [88:57] free_total,
    // [98:89] live_discarded, rest zero
    output logic [fcfl_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import fcfl_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Sequencing and handshake control.
    fcfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // Pool state, link memory and result register.
    fcfl_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_opcode      (s_axis_tuser),
        .i_chunk_index (s_axis_tdata[IDX_W-1:0]),
        .o_result      (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: tb/fixed_chunk_free_list_allocator_tb.sv
// Self-checking testbench for the fixed-chunk free-list allocator.
// It predicts every result in a behavioral pool model and checks the output stream field by field.
// It depends only on fcfl_pkg and the fixed_chunk_free_list_allocator top level.
`default_nettype none

module fixed_chunk_free_list_allocator_tb;
    import fcfl_pkg::*;

    localparam int FREE_COUNT_CAP = 1023;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int DRAIN_CYCLES   = 8;

    // Bit positions of the result fields in m_axis_tdata.
    localparam int GRANT_LSB = 0;
    localparam int STS_LSB   = GRANT_LSB + IDX_W;
    localparam int FC_LSB    = STS_LSB + STS_W;
    localparam int BLK_LSB   = FC_LSB + FC_W;
    localparam int ALLOC_LSB = BLK_LSB + BLKO_W;
    localparam int FREE_LSB  = ALLOC_LSB + CNT_W;
    localparam int LIVE_LSB  = FREE_LSB + CNT_W;

    typedef struct {
        logic [IDX_W-1:0]  granted;
        t_status           status;
        logic [FC_W-1:0]   free_chunks;
        logic [BLKO_W-1:0] blocks;
        logic [CNT_W-1:0]  alloc_total;
        logic [CNT_W-1:0]  free_total;
        logic [FC_W-1:0]   live;
    } t_pool_stats;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [8:0] chunk_index, rest zero
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // [1:0] opcode
    logic [OPC_W-1:0]      s_axis_tuser = OP_NOP;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [8:0] granted_index, [10:9] status, [20:11] free_chunks, [24:21] blocks_taken,
    // [56:25] alloc_total, [88:57] free_total, [98:89] live_discarded
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // Shadow copy of the pool state.
    logic [IDX_W-1:0] link_mem [INDEX_SPACE];
    bit               tail_mem [INDEX_SPACE];
    logic [IDX_W-1:0] list_top = '0;
    bit               list_valid = 1'b0;
    int unsigned      fresh_next = 0;
    int unsigned      pool_blocks = 0;
    int unsigned      free_est = 0;
    logic [CNT_W-1:0] alloc_tally = '0;
    logic [CNT_W-1:0] free_tally = '0;

    t_pool_stats      expected_stats_q[$];
    logic [IDX_W-1:0] live_chunks_q[$];
    int               op_tally[4] = '{default: 0};
    int               checked_count = 0;
    int               mismatch_count = 0;
    int               cycle_count = 0;
    bit               steady_traffic = 1'b0;

    fixed_chunk_free_list_allocator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Chunks covered by a given number of taken blocks, capped at the index space.
    function automatic int unsigned taken_range(input int unsigned blocks);
        int unsigned span;
        span = blocks * CHUNKS_PER_BLOCK;
        return (span > INDEX_SPACE) ? INDEX_SPACE : span;
    endfunction

    // Advance the shadow pool by one operation and return the statistics it reports.
    function automatic t_pool_stats pool_step(input t_opcode op, input logic [IDX_W-1:0] idx);
        t_pool_stats r;
        int unsigned range_now;
        int unsigned range_grown;
        range_now = taken_range(pool_blocks);
        r.granted = '0;
        r.status  = ST_OK;
        r.live    = '0;
        case (op)
            OP_ALLOC: begin
                if (list_valid) begin
                    r.granted  = list_top;
                    list_valid = !tail_mem[r.granted];
                    list_top   = link_mem[r.granted];
                end else if (fresh_next < range_now) begin
                    r.granted = IDX_W'(fresh_next);
                    fresh_next++;
                end else if (pool_blocks < MAX_BLOCKS && range_now < INDEX_SPACE) begin
                    range_grown = taken_range(pool_blocks + 1);
                    pool_blocks++;
                    free_est += range_grown - range_now;
                    if (free_est > FREE_COUNT_CAP) free_est = FREE_COUNT_CAP;
                    fresh_next = range_now;
                    r.granted  = IDX_W'(fresh_next);
                    fresh_next++;
                end else begin
                    r.status = ST_NO_SPACE;
                end
                if (r.status == ST_OK) begin
                    if (free_est > 0) free_est--;
                    alloc_tally++;
                end
            end
            OP_FREE: begin
                // No double-free check: the chunk is simply pushed again.
                if (idx >= range_now) begin
                    r.status = ST_OUT_OF_RANGE;
                end else begin
                    link_mem[idx] = list_top;
                    tail_mem[idx] = !list_valid;
                    list_top      = idx;
                    list_valid    = 1'b1;
                    if (free_est < FREE_COUNT_CAP) free_est++;
                    free_tally++;
                end
            end
            OP_CLEANUP: begin
                r.live     = (range_now > free_est) ? FC_W'(range_now - free_est) : '0;
                list_valid = 1'b0;
                list_top   = '0;
                fresh_next = 0;
                free_est   = range_now;
            end
            default: begin
            end
        endcase
        r.free_chunks = FC_W'(free_est);
        r.blocks      = BLKO_W'(pool_blocks);
        r.alloc_total = alloc_tally;
        r.free_total  = free_tally;
        return r;
    endfunction

    // Offer one transaction, wait for the handshake and record its expected result.
    task automatic send_op(input t_opcode op, input logic [IDX_W-1:0] idx,
                           output t_pool_stats predicted);
        int gap;
        gap = 0;
        if (!steady_traffic) begin
            while ($urandom_range(99) < 13) gap++;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= IN_DATA_W'(idx);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = pool_step(op, idx);
        expected_stats_q.insert(expected_stats_q.size(), predicted);
        op_tally[op]++;
        if (op == OP_ALLOC && predicted.status == ST_OK) begin
            live_chunks_q.insert(live_chunks_q.size(), predicted.granted);
        end
        if (op == OP_CLEANUP) live_chunks_q.delete();
    endtask

    // Hold the input side quiet until every outstanding result has been checked.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_stats_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic compare_field(input string field, input logic [CNT_W-1:0] want,
                                 input logic [CNT_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    // Field extremes, every opcode, out-of-range frees, double frees and cleanup clamping.
    task automatic test_directed_basics();
        t_pool_stats got;
        send_op(OP_FREE, '0, got);
        send_op(OP_FREE, '1, got);
        send_op(OP_ALLOC, '1, got);
        send_op(OP_ALLOC, '0, got);
        send_op(OP_ALLOC, 9'h155, got);
        send_op(OP_FREE, IDX_W'(CHUNKS_PER_BLOCK), got);
        send_op(OP_FREE, 9'd2, got);
        send_op(OP_FREE, 9'd1, got);
        send_op(OP_FREE, 9'd1, got);
        send_op(OP_ALLOC, '0, got);
        send_op(OP_ALLOC, '0, got);
        send_op(OP_ALLOC, '0, got);
        send_op(OP_ALLOC, '0, got);
        send_op(OP_NOP, '1, got);
        send_op(OP_CLEANUP, '1, got);
        send_op(OP_ALLOC, '0, got);
        send_op(OP_FREE, IDX_W'(CHUNKS_PER_BLOCK - 1), got);
        send_op(OP_FREE, IDX_W'(CHUNKS_PER_BLOCK - 1), got);
        send_op(OP_FREE, IDX_W'(CHUNKS_PER_BLOCK - 1), got);
        // More free chunks than the taken range, so no live chunks are reported.
        send_op(OP_CLEANUP, '0, got);
        send_op(OP_FREE, 9'h0AA, got);
        send_op(OP_NOP, '0, got);
        wait_drained();
    endtask

    // Allocate until every block is taken and allocation is refused.
    task automatic test_fill_to_exhaustion();
        t_pool_stats got;
        int refusals;
        int guard;
        refusals = 0;
        steady_traffic = 1'b1;
        for (guard = 0; guard < 600 && refusals < 3; guard++) begin
            if (guard == 200) steady_traffic = 1'b0;
            send_op(OP_ALLOC, IDX_W'($urandom), got);
            if (got.status == ST_NO_SPACE) refusals++;
        end
        steady_traffic = 1'b0;
        wait_drained();
    endtask

    // Mixed traffic: allocates, frees mostly of live chunks with stray frees as noise, no-ops and cleanups.
    task automatic test_random_traffic();
        t_pool_stats      got;
        logic [IDX_W-1:0] idx;
        int               pick;
        int               slot;
        for (int n = 0; n < 170; n++) begin
            pick = $urandom_range(99);
            idx  = IDX_W'($urandom);
            if (pick < 45) begin
                send_op(OP_ALLOC, idx, got);
            end else if (pick < 85) begin
                if (live_chunks_q.size() > 0 && $urandom_range(3) != 0) begin
                    slot = $urandom_range(live_chunks_q.size() - 1);
                    idx  = live_chunks_q[slot];
                    live_chunks_q.delete(slot);
                end
                send_op(OP_FREE, idx, got);
            end else if (pick < 93) begin
                send_op(OP_NOP, idx, got);
            end else begin
                send_op(OP_CLEANUP, idx, got);
            end
        end
        wait_drained();
    endtask

    // Result side: random backpressure and a field-by-field check of each transaction.
    always @(posedge i_clk) begin : result_check
        t_pool_stats want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_stats_q.size() == 0) begin
                    $error("result transaction arrived with no expectation pending");
                    mismatch_count++;
                end else begin
                    want = expected_stats_q.pop_front();
                    checked_count++;
                    compare_field("granted_index", CNT_W'(want.granted),
                                  CNT_W'(m_axis_tdata[GRANT_LSB +: IDX_W]));
                    compare_field("status", CNT_W'(want.status),
                                  CNT_W'(m_axis_tdata[STS_LSB +: STS_W]));
                    compare_field("free_chunks", CNT_W'(want.free_chunks),
                                  CNT_W'(m_axis_tdata[FC_LSB +: FC_W]));
                    compare_field("blocks_taken", CNT_W'(want.blocks),
                                  CNT_W'(m_axis_tdata[BLK_LSB +: BLKO_W]));
                    compare_field("alloc_total", want.alloc_total,
                                  m_axis_tdata[ALLOC_LSB +: CNT_W]);
                    compare_field("free_total", want.free_total,
                                  m_axis_tdata[FREE_LSB +: CNT_W]);
                    compare_field("live_discarded", CNT_W'(want.live),
                                  CNT_W'(m_axis_tdata[LIVE_LSB +: FC_W]));
                end
            end
            m_axis_tready <= steady_traffic || ($urandom_range(99) >= 13);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == WATCHDOG_LIMIT) begin
            $error("run did not finish within %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_basics();
        test_fill_to_exhaustion();
        test_random_traffic();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_stats_q.size() != 0) begin
            $error("%0d expected results never arrived", expected_stats_q.size());
            mismatch_count++;
        end

        $display("Run covered %0d allocates, %0d frees, %0d cleanups and %0d no-ops,",
                 op_tally[OP_ALLOC], op_tally[OP_FREE], op_tally[OP_CLEANUP], op_tally[OP_NOP]);
        $display("with directed corners, pool exhaustion and mixed traffic; %0d results checked.",
                 checked_count);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/fcfl_pkg.sv
rtl/fcfl_dp.sv
rtl/fcfl_ctrl.sv
rtl/fixed_chunk_free_list_allocator.sv
tb/fixed_chunk_free_list_allocator_tb.sv
